FILE: rtl/core/ipmd_pkg.sv
// Package for the incremental PID motor drive: widths, fixed constants,
// register index codes and the structs passed between the pipeline modules.
// Depends on nothing; every other file imports it.
package ipmd_pkg;

    // Control tick length and PWM counter period.
    localparam int TICK_PERIOD = 10;
    localparam int PWM_PERIOD  = 4199;

    // Field widths.
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = SPEED_W + 1;
    localparam int GAIN_W    = 24;
    localparam int ACC_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int IPART_W   = ACC_W - FRAC_W;
    localparam int MAG_W     = IPART_W + 1;
    localparam int DUTY_W    = 13;
    localparam int CFG_IDX_W = 2;

    // Division of a gain (or twice a gain) by the tick period is done as a
    // multiply by a rounded-up reciprocal. The shift is chosen so that the
    // rounding error never reaches the next integer for operands below 2^25.
    localparam int DIV_IN_W  = GAIN_W + 1;
    localparam int T_LOG     = $clog2(TICK_PERIOD);
    localparam int DIV_SHIFT = DIV_IN_W + T_LOG;
    localparam int RECIP_W   = DIV_IN_W + 2;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TICK_PERIOD) - 64'd1) / 64'(TICK_PERIOD));
    localparam int DIV_PROD_W = DIV_IN_W + RECIP_W;

    // Coefficient, product and sum widths.
    localparam int Q_W    = GAIN_W + T_LOG + 3;
    localparam int PROD_W = Q_W + ERR_W;
    localparam int SUM_W  = PROD_W + 3;

    // Register index codes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DERIV_GAIN = 2'd2
    } cfg_reg_t;

    // Velocity-form coefficients, signed Q.16.
    typedef struct packed {
        logic signed [Q_W-1:0] q0;
        logic signed [Q_W-1:0] q1;
        logic signed [Q_W-1:0] q2;
    } coef_t;

    // Error history: newest, previous and the one before.
    typedef struct packed {
        logic signed [ERR_W-1:0] e0;
        logic signed [ERR_W-1:0] e1;
        logic signed [ERR_W-1:0] e2;
    } err_hist_t;

    // Per-stage load strobes of the pipeline.
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
        logic out_load;
    } pipe_ctl_t;

endpackage

FILE: rtl/core/ipmd_in_if.sv
// Input channel of the motor drive: target and measured speed per beat.
// Depends on ipmd_pkg for the field widths.
interface ipmd_in_if import ipmd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_setpoint;
    logic signed [SPEED_W-1:0] measured_speed;

    modport source (output valid, output speed_setpoint, output measured_speed, input ready);
    modport sink   (input valid, input speed_setpoint, input measured_speed, output ready);
endinterface

FILE: rtl/core/ipmd_out_if.sv
// Result channel of the motor drive: direction, PWM compare and drive value.
// Depends on ipmd_pkg for the field widths.
interface ipmd_out_if import ipmd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    drive_ccw;
    logic [DUTY_W-1:0]       pwm_duty;
    logic signed [ACC_W-1:0] drive_value;

    modport source (output valid, output drive_ccw, output pwm_duty, output drive_value,
                    input ready);
    modport sink   (input valid, input drive_ccw, input pwm_duty, input drive_value,
                    output ready);
endinterface

FILE: rtl/core/ipmd_cfg_if.sv
// Configuration write channel of the motor drive: register index and data.
// Depends on ipmd_pkg for the index and gain widths.
interface ipmd_cfg_if import ipmd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ipmd_coef.sv
// Gain registers and the registered velocity-form coefficients q0, q1, q2.
// Depends on ipmd_pkg.
module ipmd_coef import ipmd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [GAIN_W-1:0]    wr_data,
    output coef_t                coef
);

    localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(327680);
    localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(655);
    localparam logic [GAIN_W-1:0] KD_RESET = GAIN_W'(655);
    localparam logic [Q_W-1:0]    TICK_Q   = Q_W'(TICK_PERIOD);

    logic [GAIN_W-1:0]     kp_reg, ki_reg, kd_reg;
    logic [DIV_PROD_W-1:0] kd_div_prod, kd2_div_prod;
    logic [Q_W-1:0]        kd_t, kd2_t, ki_t;
    coef_t                 coef_reg, coef_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= KP_RESET;
            ki_reg <= KI_RESET;
            kd_reg <= KD_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_PROP_GAIN:  kp_reg <= wr_data;
                REG_INTEG_GAIN: ki_reg <= wr_data;
                REG_DERIV_GAIN: kd_reg <= wr_data;
                default:        ;
            endcase
        end
    end

    // floor(Kd/T) and floor(2Kd/T) by reciprocal multiply, then the sums.
    always_comb
    begin
        kd_div_prod  = DIV_PROD_W'(kd_reg) * DIV_PROD_W'(DIV_RECIP);
        kd2_div_prod = DIV_PROD_W'({kd_reg, 1'b0}) * DIV_PROD_W'(DIV_RECIP);
        kd_t         = Q_W'(kd_div_prod >> DIV_SHIFT);
        kd2_t        = Q_W'(kd2_div_prod >> DIV_SHIFT);
        ki_t         = Q_W'(ki_reg) * TICK_Q;
        coef_next.q0 = Q_W'(kp_reg) + kd_t;
        coef_next.q1 = ki_t - kd2_t - Q_W'(kp_reg);
        coef_next.q2 = -kd_t;
    end

    // Follows the gains in the next cycle.
    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

FILE: rtl/core/ipmd_err_hist.sv
// First pipeline stage: forms the new speed error and shifts the history.
// Depends on ipmd_pkg.
module ipmd_err_hist import ipmd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pipe_ctl_t                 ctl,
    input  logic signed [SPEED_W-1:0] speed_setpoint,
    input  logic signed [SPEED_W-1:0] measured_speed,
    output err_hist_t                 hist
);

    err_hist_t hist_reg, hist_next;

    always_comb
    begin
        hist_next.e0 = ERR_W'(speed_setpoint) - ERR_W'(measured_speed);
        hist_next.e1 = hist_reg.e0;
        hist_next.e2 = hist_reg.e1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_reg <= '0;
        else if (ctl.s1_load)
            hist_reg <= hist_next;
    end

    assign hist = hist_reg;

endmodule

FILE: rtl/core/ipmd_accum.sv
// Second and third pipeline stages: three registered products, then the
// saturating Q16.16 accumulator update. Depends on ipmd_pkg.
module ipmd_accum import ipmd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pipe_ctl_t               ctl,
    input  coef_t                   coef,
    input  err_hist_t               hist,
    output logic signed [ACC_W-1:0] accum
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod0_reg, prod1_reg, prod2_reg;
    logic signed [PROD_W-1:0] prod0_next, prod1_next, prod2_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [ACC_W-1:0]  accum_reg, accum_next;
    logic                     sum_fits;

    always_comb
    begin
        prod0_next = PROD_W'(coef.q0) * PROD_W'(hist.e0);
        prod1_next = PROD_W'(coef.q1) * PROD_W'(hist.e1);
        prod2_next = PROD_W'(coef.q2) * PROD_W'(hist.e2);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
        begin
            prod0_reg <= prod0_next;
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
    end

    // The sum fits when every bit above the Q16.16 sign equals that sign.
    always_comb
    begin
        sum = SUM_W'(prod0_reg) + SUM_W'(prod1_reg) + SUM_W'(prod2_reg) + SUM_W'(accum_reg);
        sum_fits = (sum[SUM_W-1:ACC_W-1] == '0) || (sum[SUM_W-1:ACC_W-1] == '1);
        if (sum_fits)
            accum_next = sum[ACC_W-1:0];
        else if (sum[SUM_W-1])
            accum_next = ACC_MIN;
        else
            accum_next = ACC_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            accum_reg <= '0;
        else if (ctl.s3_load)
            accum_reg <= accum_next;
    end

    assign accum = accum_reg;

endmodule

FILE: rtl/core/ipmd_drive_out.sv
// Output stage: integer part of the drive, direction and clamped PWM compare,
// held in the result register. Depends on ipmd_pkg.
module ipmd_drive_out import ipmd_pkg::*;
(
    input  logic                    clk,
    input  pipe_ctl_t               ctl,
    input  logic signed [ACC_W-1:0] accum,
    output logic                    drive_ccw,
    output logic [DUTY_W-1:0]       pwm_duty,
    output logic signed [ACC_W-1:0] drive_value
);

    localparam logic signed [ACC_W-1:0] FRAC_ROUND = ACC_W'((1 << FRAC_W) - 1);
    localparam logic [MAG_W-1:0]        PWM_MAX    = MAG_W'(PWM_PERIOD);

    logic signed [ACC_W-1:0]   biased;
    logic signed [IPART_W-1:0] ipart;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          mag_clamped;
    logic                      ccw_next;
    logic                      ccw_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic signed [ACC_W-1:0]   value_reg;

    // Truncation toward zero: bias negative values before the shift.
    always_comb
    begin
        biased      = accum + (accum[ACC_W-1] ? FRAC_ROUND : '0);
        ipart       = IPART_W'(biased >>> FRAC_W);
        mag         = ipart[IPART_W-1] ? -MAG_W'(ipart) : MAG_W'(ipart);
        mag_clamped = (mag > PWM_MAX) ? PWM_MAX : mag;
        ccw_next    = !ipart[IPART_W-1] && (ipart != '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            ccw_reg   <= ccw_next;
            duty_reg  <= mag_clamped[DUTY_W-1:0];
            value_reg <= accum;
        end
    end

    assign drive_ccw   = ccw_reg;
    assign pwm_duty    = duty_reg;
    assign drive_value = value_reg;

endmodule

FILE: rtl/core/incremental_pid_motor_drive.sv
// Incremental PID speed loop for one motor: top level with pipeline control.
// An accepted input beat moves through the error, product and accumulator
// stages to the result register. Throughput: one beat per cycle; four register
// stages, each stalls only when the one after it is full and held. A gain write
// affects beats accepted from the next cycle on. Reset clears the error history,
// the accumulator, all stage valid flags and restores the default gains.
module incremental_pid_motor_drive import ipmd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    ipmd_in_if.sink   cmd,
    ipmd_out_if.source drv,
    ipmd_cfg_if.sink  cfg
);

    // Stage valid flags: error stage, product stage, accumulator stage and
    // the result register that drives the output channel.
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic v1_next, v2_next, v3_next, vo_next;
    logic en1, en2, en3, en_out;

    pipe_ctl_t               ctl;
    coef_t                   coef;
    err_hist_t               hist;
    logic signed [ACC_W-1:0] accum;

    // A stage may take new data when it is empty or when its contents move
    // on in the same cycle. This lets the pipeline absorb new beats while a
    // finished result is still waiting at the output.
    always_comb
    begin
        en_out = !vo_reg || drv.ready;
        en3    = !v3_reg || en_out;
        en2    = !v2_reg || en3;
        en1    = !v1_reg || en2;

        ctl.s1_load  = cmd.valid && en1;
        ctl.s2_load  = v1_reg && en2;
        ctl.s3_load  = v2_reg && en3;
        ctl.out_load = v3_reg && en_out;

        v1_next = en1 ? cmd.valid : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
        vo_next = en_out ? v3_reg : vo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    assign cmd.ready = en1;
    assign drv.valid = vo_reg;

    // Gain writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    ipmd_coef u_coef
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .coef     (coef)
    );

    ipmd_err_hist u_err_hist
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .speed_setpoint (cmd.speed_setpoint),
        .measured_speed (cmd.measured_speed),
        .hist           (hist)
    );

    ipmd_accum u_accum
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .coef  (coef),
        .hist  (hist),
        .accum (accum)
    );

    ipmd_drive_out u_drive_out
    (
        .clk         (clk),
        .ctl         (ctl),
        .accum       (accum),
        .drive_ccw   (drv.drive_ccw),
        .pwm_duty    (drv.pwm_duty),
        .drive_value (drv.drive_value)
    );

    // An accepted beat always occupies the error stage in the next cycle.
    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> v1_reg)
        else $error("accepted beat did not enter the error stage");

    // Direction is counter-clockwise exactly when the integer drive is positive.
    a_ccw_matches_value: assert property (@(posedge clk) disable iff (!rst_n)
        drv.valid |-> (drv.drive_ccw == (!drv.drive_value[ACC_W-1]
                       && (drv.drive_value[ACC_W-2:FRAC_W] != '0))))
        else $error("drive direction disagrees with drive value");

    // The PWM compare never exceeds the period.
    a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        drv.valid |-> (drv.pwm_duty <= DUTY_W'(PWM_PERIOD)))
        else $error("PWM compare above period");

endmodule
